### rtl/tat_pkg.sv
package tat_pkg;

  // Table geometry.
  localparam int NUM_SITUATIONS = 1024;
  localparam int ACT_SLOTS      = 16;
  localparam int SIT_W          = $clog2(NUM_SITUATIONS);
  localparam int ACT_W          = $clog2(ACT_SLOTS);
  localparam int ADDR_W         = SIT_W + ACT_W;
  localparam int CNT_W          = $clog2(ACT_SLOTS + 1);

  // Field widths of the stream words.
  localparam int SIT_FIELD_W = 10;
  localparam int ACT_FIELD_W = 4;
  localparam int MASK_W      = 16;
  localparam int RND_W       = 16;
  localparam int TOK_W       = 24;
  localparam int SCALE_W     = 16;
  localparam int NACT_W      = 5;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 32;

  // Arithmetic widths. A sum of all entries of a row fits SUM_W bits.
  localparam int Q_FRAC     = 12;
  localparam int SUM_W      = TOK_W + ACT_W;
  localparam int PROD_W     = SUM_W + RND_W;
  localparam int TGT_SHIFT  = 28;
  localparam int TGT_W      = PROD_W - TGT_SHIFT;
  localparam int REM_W      = TGT_W + Q_FRAC + 1;
  localparam int LPROD_W    = SCALE_W + TOK_W;
  localparam int LVAL_W     = LPROD_W - Q_FRAC + 2;

  localparam logic [TOK_W-1:0]  RESET_TOKENS  = 24'd40960;
  localparam logic [TOK_W-1:0]  RESET_FLOOR   = 24'd41;
  localparam logic [NACT_W-1:0] RESET_ACTIONS = 5'd16;
  localparam logic [TOK_W-1:0]  TOK_MAX       = 24'hFFFFFF;
  localparam logic [SUM_W-1:0]  ONE_TOKEN     = SUM_W'(4096);

  typedef enum logic [1:0] {
    CFG_ACTIONS = 2'd0,
    CFG_START   = 2'd1,
    CFG_FLOOR   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    REQ_CHOOSE = 1'b0,
    REQ_LEARN  = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_REFILL,
    ST_MUL,
    ST_WALK,
    ST_LREAD,
    ST_LMUL,
    ST_LWRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [NACT_W-1:0] actions_in_use;
    logic [TOK_W-1:0]  refill_tokens;
    logic [TOK_W-1:0]  token_floor;
  } cfg_t;

  typedef struct packed {
    req_t                     req_type;
    logic [SIT_FIELD_W-1:0]   situation;
    logic [ACT_FIELD_W-1:0]   action;
    logic [MASK_W-1:0]        permitted_mask;
    logic [RND_W-1:0]         random_fraction;
    logic signed [TOK_W-1:0]  token_add;
    logic [SCALE_W-1:0]       token_scale;
  } item_t;

  typedef struct packed {
    logic [ACT_FIELD_W-1:0] chosen_action;
    logic                   underflow;
    logic [TOK_W-1:0]       updated_tokens;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [TOK_W-1:0]  data;
  } ram_wr_t;

endpackage

### rtl/tat_ram.sv
module tat_ram #(
  parameter int AW = 14,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tat_seq.sv
module tat_seq import tat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_vld,
  output logic              in_rdy,
  input  item_t             in_item,
  output logic              res_vld,
  input  logic              res_rdy,
  output res_t              res,
  output ram_wr_t           ram_wr,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [TOK_W-1:0]  ram_rdata
);

  state_t state, state_next;

  logic [ADDR_W-1:0]       clr_cnt;
  item_t                   item;
  logic [CNT_W-1:0]        n_live;
  logic [CNT_W-1:0]        idx;
  logic                    rd_vld;
  logic [ACT_W-1:0]        rd_idx;
  logic [SUM_W-1:0]        sum;
  logic [CNT_W-1:0]        cnt;
  logic                    underflow;
  logic signed [REM_W-1:0] rem;
  logic                    found;
  logic [ACT_W-1:0]        chosen;
  logic [LPROD_W-1:0]      lprod;
  res_t                    res_q;

  logic [SIT_W-1:0]         sit_idx;
  logic                     issue;
  logic                     pass_end;
  logic                     hit;
  logic signed [REM_W-1:0]  rem_new;
  logic [PROD_W-1:0]        tgt_prod;
  logic signed [LVAL_W-1:0] lsum;
  logic [TOK_W-1:0]         lval;
  logic [NACT_W-1:0]        n_cfg;

  // Situation index wraps at the table size, a power of two.
  assign sit_idx  = item.situation[SIT_W-1:0];
  assign issue    = (idx < n_live);
  assign pass_end = !issue && !rd_vld;
  assign hit      = rd_vld && item.permitted_mask[rd_idx];
  assign n_cfg    = (cfg.actions_in_use > NACT_W'(ACT_SLOTS)) ?
                    NACT_W'(ACT_SLOTS) : cfg.actions_in_use;

  // Walk step: subtract the weight read back from memory.
  assign rem_new  = rem - $signed({{(REM_W - TOK_W){1'b0}}, ram_rdata});
  assign tgt_prod = sum * PROD_W'(item.random_fraction);

  // Learn update: add + scale * old, clamped at the floor and at the maximum.
  always_comb begin
    lsum = LVAL_W'(item.token_add) +
           $signed({2'b00, lprod[LPROD_W-1:Q_FRAC]});
    if (lsum <= $signed({{(LVAL_W - TOK_W){1'b0}}, cfg.token_floor})) begin
      lval = cfg.token_floor;
    end else if (lsum > $signed({{(LVAL_W - TOK_W){1'b0}}, TOK_MAX})) begin
      lval = TOK_MAX;
    end else begin
      lval = lsum[TOK_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == {ADDR_W{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_vld) state_next = (in_item.req_type == REQ_LEARN) ? ST_LREAD : ST_SUM;
      end
      ST_SUM: begin
        if (pass_end) state_next = (sum <= ONE_TOKEN) ? ST_REFILL : ST_MUL;
      end
      ST_REFILL: begin
        if (!issue) state_next = ST_MUL;
      end
      ST_MUL:    state_next = ST_WALK;
      ST_WALK: begin
        if (pass_end) state_next = ST_DONE;
      end
      ST_LREAD:  state_next = ST_LMUL;
      ST_LMUL:   state_next = ST_LWRITE;
      ST_LWRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (res_rdy) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory control.
  always_comb begin
    in_rdy      = 1'b0;
    res_vld     = 1'b0;
    ram_wr.we   = 1'b0;
    ram_wr.addr = {sit_idx, idx[ACT_W-1:0]};
    ram_wr.data = cfg.refill_tokens;
    ram_raddr   = {sit_idx, idx[ACT_W-1:0]};
    unique case (state)
      ST_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = clr_cnt;
        ram_wr.data = RESET_TOKENS;
      end
      ST_IDLE:   in_rdy = 1'b1;
      ST_REFILL: ram_wr.we = issue && item.permitted_mask[idx[ACT_W-1:0]];
      ST_LREAD:  ram_raddr = {sit_idx, item.action[ACT_W-1:0]};
      ST_LWRITE: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = {sit_idx, item.action[ACT_W-1:0]};
        ram_wr.data = lval;
      end
      ST_DONE:   res_vld = 1'b1;
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      rd_vld  <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt + ADDR_W'(1);
      rd_vld  <= ((state == ST_SUM) || (state == ST_WALK)) && issue;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_idx <= idx[ACT_W-1:0];
    case (state)
      ST_IDLE: begin
        item      <= in_item;
        n_live    <= n_cfg;
        idx       <= '0;
        sum       <= '0;
        cnt       <= '0;
        underflow <= 1'b0;
        found     <= 1'b0;
        chosen    <= '0;
      end
      ST_SUM: begin
        if (issue) idx <= idx + CNT_W'(1);
        if (hit) begin
          sum <= sum + SUM_W'(ram_rdata);
          cnt <= cnt + CNT_W'(1);
        end
        if (pass_end) begin
          idx <= '0;
          if (sum <= ONE_TOKEN) underflow <= 1'b1;
        end
      end
      ST_REFILL: begin
        if (issue) begin
          idx <= idx + CNT_W'(1);
        end else begin
          sum <= SUM_W'(cnt) * SUM_W'(cfg.refill_tokens);
          idx <= '0;
        end
      end
      ST_MUL: begin
        rem <= $signed({1'b0, tgt_prod[PROD_W-1:TGT_SHIFT], {Q_FRAC{1'b0}}});
      end
      ST_WALK: begin
        if (issue) idx <= idx + CNT_W'(1);
        if (hit && !found) begin
          rem <= rem_new;
          if (rem_new <= 0) begin
            found  <= 1'b1;
            chosen <= rd_idx;
          end
        end
        if (pass_end) begin
          res_q.chosen_action  <= ACT_FIELD_W'(chosen);
          res_q.underflow      <= underflow;
          res_q.updated_tokens <= '0;
        end
      end
      ST_LMUL: begin
        lprod <= LPROD_W'(item.token_scale) * LPROD_W'(ram_rdata);
      end
      ST_LWRITE: begin
        res_q.chosen_action  <= '0;
        res_q.underflow      <= 1'b0;
        res_q.updated_tokens <= lval;
      end
      default: begin
      end
    endcase
  end

  assign res = res_q;

endmodule

### rtl/boxes_token_action_selector.sv
// Choose: sums the permitted entries among the first min(actions_in_use, 16) of the row,
// refills them if the sum is one token or less, then walks them; learn: reads, scales
// and writes back one entry. One request is in work at a time, and the next word is
// taken in the cycle after the result leaves the sequencer; the single memory read port
// serves one entry a cycle. Reset (synchronous, active high) clears control, loads the register
// defaults and starts a pass that writes 10.0 to every entry; no word is taken meanwhile.
module boxes_token_action_selector import tat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // situation, action, permitted_mask, random_fraction, token_add, token_scale
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // chosen_action, underflow, updated_tokens
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [TOK_W-1:0]      cfg_data
);

  cfg_t              cfg;
  item_t             in_item;
  res_t              res;
  logic              res_vld;
  logic              res_rdy;
  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TOK_W-1:0]  ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.actions_in_use <= RESET_ACTIONS;
      cfg.refill_tokens  <= RESET_TOKENS;
      cfg.token_floor    <= RESET_FLOOR;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIONS: cfg.actions_in_use <= cfg_data[NACT_W-1:0];
        CFG_START:   cfg.refill_tokens  <= cfg_data;
        CFG_FLOOR:   cfg.token_floor    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Unpack the input word.
  assign in_item.req_type        = req_t'(s_tuser);
  assign in_item.situation       = s_tdata[9:0];
  assign in_item.action          = s_tdata[13:10];
  assign in_item.permitted_mask  = s_tdata[29:14];
  assign in_item.random_fraction = s_tdata[45:30];
  assign in_item.token_add       = $signed(s_tdata[69:46]);
  assign in_item.token_scale     = s_tdata[85:70];

  tat_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_vld    (s_tvalid),
    .in_rdy    (s_tready),
    .in_item   (in_item),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res       (res),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tat_ram #(
    .AW (ADDR_W),
    .DW (TOK_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register; the sequencer can take the next word while it is full.
  assign res_rdy = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_rdy) begin
      m_tvalid <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && res_vld) begin
      m_tdata <= {3'b000, res.updated_tokens, res.underflow, res.chosen_action};
    end
  end

endmodule

### rtl/tat_checker.sv
module tat_checker import tat_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // The table clearing pass blocks input right after reset.
  a_clear_blocks: assert property (@(posedge clk)
    $past(rst) |-> !s_tready)
    else $error("input ready during table clear");

  // One request in work: ready drops after each accepted word.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while one is in work");

  // A learn result carries no action and no underflow flag.
  a_learn_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[28:5] != 24'd0) |-> (m_tdata[4:0] == 5'd0))
    else $error("learn result with action or underflow set");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:29] == 3'd0))
    else $error("nonzero padding in result word");

endmodule

bind boxes_token_action_selector tat_checker u_tat_checker (.*);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import tat_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int PRESSURE_HOLD  = 200;
  localparam int TABLE_DEPTH    = NUM_SITUATIONS * ACT_SLOTS;
  // Register index past the last register; the block must ignore writes to it.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam res_t       NO_TYPED  = '0;

  typedef struct {
    item_t it;
    bit    known;
    res_t  want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [TOK_W-1:0]      cfg_data = '0;

  boxes_token_action_selector u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the token table and the registers, kept in step with accepted words.
  logic [TOK_W-1:0]  token_mirror [TABLE_DEPTH];
  logic [NACT_W-1:0] cfg_actions;
  logic [TOK_W-1:0]  cfg_start;
  logic [TOK_W-1:0]  cfg_floor;

  res_t      pending_results [$];
  stim_row_t directed_rows [$];
  int        err_cnt = 0;
  int        results_seen = 0;
  int        stall_cycles = 0;
  bit        quiet = 1'b0;
  bit        pressure_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one request to the mirror and returns the result word it must produce.
  function automatic res_t apply_request(item_t it);
    int     base, live, cnt, i;
    longint sum, remain, v, prod;
    bit     hit;
    res_t   r;
    r    = '0;
    base = int'(it.situation) * ACT_SLOTS;
    if (it.req_type == REQ_LEARN) begin
      prod = (longint'(it.token_scale) * longint'(token_mirror[base + it.action]))
             >> Q_FRAC;
      v = longint'($signed(it.token_add)) + prod;
      if (v <= longint'(cfg_floor)) v = longint'(cfg_floor);
      else if (v > longint'(TOK_MAX)) v = longint'(TOK_MAX);
      token_mirror[base + it.action] = TOK_W'(v);
      r.updated_tokens = TOK_W'(v);
    end else begin
      live = (cfg_actions > ACT_SLOTS) ? ACT_SLOTS : int'(cfg_actions);
      sum  = 0;
      cnt  = 0;
      for (i = 0; i < live; i++) begin
        if (it.permitted_mask[i]) begin
          sum += longint'(token_mirror[base + i]);
          cnt++;
        end
      end
      // One token or less in play: refill the permitted entries first.
      if (sum <= longint'(ONE_TOKEN)) begin
        for (i = 0; i < live; i++) begin
          if (it.permitted_mask[i]) token_mirror[base + i] = cfg_start;
        end
        sum = longint'(cnt) * longint'(cfg_start);
        r.underflow = 1'b1;
      end
      // Whole-token target, then walk the weights until the remainder runs out.
      remain = ((sum * longint'(it.random_fraction)) >> TGT_SHIFT) << Q_FRAC;
      hit    = 1'b0;
      for (i = 0; i < live; i++) begin
        if (!hit && it.permitted_mask[i]) begin
          remain -= longint'(token_mirror[base + i]);
          if (remain <= 0) begin
            r.chosen_action = ACT_FIELD_W'(i);
            hit = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic item_t request(req_t rq, int sit, int act, logic [15:0] mask,
                                    logic [15:0] rnd, logic [23:0] add,
                                    logic [15:0] scale);
    item_t it;
    it.req_type        = rq;
    it.situation       = SIT_FIELD_W'(sit);
    it.action          = ACT_FIELD_W'(act);
    it.permitted_mask  = mask;
    it.random_fraction = rnd;
    it.token_add       = add;
    it.token_scale     = scale;
    return it;
  endfunction

  // Most traffic hits a few hot situations, so learning and choosing interact and
  // decaying learns drive rows down to the refill threshold.
  function automatic item_t random_request();
    item_t       it;
    int unsigned pick;
    it.req_type  = ($urandom_range(0, 9) < 4) ? REQ_LEARN : REQ_CHOOSE;
    it.situation = ($urandom_range(0, 3) != 0) ? SIT_FIELD_W'($urandom_range(0, 7))
                                               : SIT_FIELD_W'($urandom());
    it.action    = ACT_FIELD_W'($urandom());
    pick = $urandom_range(0, 7);
    case (pick)
      0: it.permitted_mask = 16'h0000;
      1: it.permitted_mask = 16'hFFFF;
      2, 3: begin
        it.permitted_mask = (16'h1 << $urandom_range(0, 15)) |
                            (16'h1 << $urandom_range(0, 15));
      end
      default: it.permitted_mask = 16'($urandom());
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: it.random_fraction = 16'h0000;
      1: it.random_fraction = 16'hFFFF;
      default: it.random_fraction = 16'($urandom());
    endcase
    pick = $urandom_range(0, 7);
    if (pick < 4) begin
      it.token_add   = 24'(-int'($urandom_range(0, 8192)));
      it.token_scale = 16'($urandom_range(0, 2047));
    end else if (pick == 4) begin
      it.token_add   = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      it.token_scale = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      it.token_add   = 24'($urandom());
      it.token_scale = 16'($urandom());
    end
    return it;
  endfunction

  task automatic add_row(item_t it, bit known, res_t want);
    stim_row_t row;
    row.it    = it;
    row.known = known;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Offers one word, sometimes after a random gap, and records its expected result
  // once the word is accepted.
  task automatic send_item(item_t it, bit known, res_t want);
    res_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tdata  <= {2'b00, it.token_scale, it.token_add, it.random_fraction,
                 it.permitted_mask, it.action, it.situation};
    s_tuser  <= it.req_type;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_request(it);
    pending_results.push_back(known ? want : predicted);
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(random_request(), 1'b0, NO_TYPED);
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [TOK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_ACTIONS: cfg_actions = val[NACT_W-1:0];
      CFG_START:   cfg_start   = val;
      CFG_FLOOR:   cfg_floor   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [NACT_W-1:0] acts, logic [TOK_W-1:0] start,
                            logic [TOK_W-1:0] flr, bit touch_spare);
    write_register(CFG_ACTIONS, TOK_W'(acts));
    write_register(CFG_START, start);
    write_register(CFG_FLOOR, flr);
    if (touch_spare) write_register(CFG_SPARE, TOK_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off to back the block up, and an
  // always-ready receiver in the closing phase.
  initial begin : result_side
    forever begin
      if (!quiet && !pressure_done && results_seen >= 300) begin
        pressure_done = 1'b1;
        m_tready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Compare each result word with the oldest expectation, field by field.
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[3:0] !== want.chosen_action)
          report_mismatch("chosen_action", m_tdata[3:0], want.chosen_action);
        if (m_tdata[4] !== want.underflow)
          report_mismatch("underflow", m_tdata[4], want.underflow);
        if (m_tdata[28:5] !== want.updated_tokens)
          report_mismatch("updated_tokens", m_tdata[28:5], want.updated_tokens);
      end
    end
  end

  // Ends a hung run: too many cycles in a row with no word moving on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : main_sequence
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) token_mirror[i] = RESET_TOKENS;
    cfg_actions = RESET_ACTIONS;
    cfg_start   = RESET_TOKENS;
    cfg_floor   = RESET_FLOOR;

    // Directed part, default registers: full row at both ends of the draw,
    // nothing permitted, floor clamp, saturation, and the refill threshold.
    add_row(request(REQ_CHOOSE, 0, 0, 16'hFFFF, 16'h0000, 24'h0, 16'h0), 1,
            res_t'{4'd0, 1'b0, 24'd0});
    add_row(request(REQ_CHOOSE, 1023, 0, 16'hFFFF, 16'hFFFF, 24'h0, 16'h0), 1,
            res_t'{4'd15, 1'b0, 24'd0});
    add_row(request(REQ_CHOOSE, 2, 9, 16'h0000, 16'h8000, 24'h0, 16'h0), 1,
            res_t'{4'd0, 1'b1, 24'd0});
    add_row(request(REQ_LEARN, 5, 3, 16'h0, 16'h0, 24'h000000, 16'h0000), 1,
            res_t'{4'd0, 1'b0, 24'd41});
    add_row(request(REQ_LEARN, 5, 3, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 16'hFFFF), 0,
            NO_TYPED);
    add_row(request(REQ_LEARN, 6, 0, 16'h0, 16'h0, 24'h7FFFFF, 16'hFFFF), 0, NO_TYPED);
    add_row(request(REQ_LEARN, 6, 0, 16'h0, 16'h0, 24'h7FFFFF, 16'hFFFF), 1,
            res_t'{4'd0, 1'b0, 24'hFFFFFF});
    add_row(request(REQ_LEARN, 6, 1, 16'h0, 16'h0, 24'h800000, 16'h0000), 1,
            res_t'{4'd0, 1'b0, 24'd41});
    add_row(request(REQ_LEARN, 6, 2, 16'h0, 16'h0, 24'h800000, 16'hFFFF), 1,
            res_t'{4'd0, 1'b0, 24'd41});
    add_row(request(REQ_LEARN, 7, 0, 16'h0, 16'h0, 24'h0, 16'h0), 1,
            res_t'{4'd0, 1'b0, 24'd41});
    add_row(request(REQ_LEARN, 7, 1, 16'h0, 16'h0, 24'h0, 16'h0), 1,
            res_t'{4'd0, 1'b0, 24'd41});
    add_row(request(REQ_CHOOSE, 7, 0, 16'h0003, 16'h8000, 24'h0, 16'h0), 0, NO_TYPED);
    add_row(request(REQ_LEARN, 8, 0, 16'h0, 16'h0, 24'd2048, 16'h0), 1,
            res_t'{4'd0, 1'b0, 24'd2048});
    add_row(request(REQ_LEARN, 8, 1, 16'h0, 16'h0, 24'd2049, 16'h0), 1,
            res_t'{4'd0, 1'b0, 24'd2049});
    add_row(request(REQ_CHOOSE, 8, 0, 16'h0003, 16'hFFFF, 24'h0, 16'h0), 0, NO_TYPED);
    add_row(request(REQ_CHOOSE, 8, 0, 16'h0001, 16'h1234, 24'h0, 16'h0), 0, NO_TYPED);
    add_row(request(REQ_LEARN, 8, 2, 16'h0, 16'h0, 24'd2048, 16'h0), 1,
            res_t'{4'd0, 1'b0, 24'd2048});
    add_row(request(REQ_LEARN, 8, 3, 16'h0, 16'h0, 24'd2048, 16'h0), 1,
            res_t'{4'd0, 1'b0, 24'd2048});
    add_row(request(REQ_CHOOSE, 8, 0, 16'h000C, 16'hFFFF, 24'h0, 16'h0), 0, NO_TYPED);
    add_row(request(REQ_CHOOSE, 9, 0, 16'h8000, 16'hFFFF, 24'h0, 16'h0), 1,
            res_t'{4'd15, 1'b0, 24'd0});
    add_row(request(REQ_CHOOSE, 9, 0, 16'hAAAA, 16'h8000, 24'h0, 16'h0), 0, NO_TYPED);
    add_row(request(REQ_LEARN, 1023, 15, 16'h0, 16'h0, 24'd1, 16'h1000), 1,
            res_t'{4'd0, 1'b0, 24'd40961});
    add_row(request(REQ_CHOOSE, 3, 0, 16'h5555, 16'hFFFF, 24'h0, 16'h0), 0, NO_TYPED);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // The block clears its table after reset before it takes the first word.
    @(posedge clk);
    while (!s_tready) @(posedge clk);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].it, directed_rows[k].known, directed_rows[k].want);
    end
    run_random(150);

    // One action in use, smallest nonzero refill count, zero floor.
    drain();
    set_config(5'd1, 24'd1, 24'd0, 1'b0);
    run_random(150);

    // No action in play, empty refill, highest floor; also poke the spare index.
    drain();
    set_config(5'd0, 24'd0, 24'hFFFFFF, 1'b1);
    run_random(100);

    // Action count above the table width, largest refill count.
    drain();
    set_config(5'd31, 24'hFFFFFF, 24'd1, 1'b0);
    run_random(150);

    drain();
    set_config(5'd17, 24'd4096, 24'd4096, 1'b0);
    run_random(150);

    drain();
    set_config(NACT_W'($urandom_range(2, 15)), TOK_W'($urandom_range(1, 200000)),
               TOK_W'($urandom_range(1, 8192)), 1'b1);
    run_random(200);

    // Closing phase back at the defaults, with no idling on either side.
    drain();
    quiet = 1'b1;
    set_config(RESET_ACTIONS, RESET_TOKENS, RESET_FLOOR, 1'b0);
    run_random(300);

    drain();
    repeat (60) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
